// File: rtl/rice_bitstream_writer_assert.svh
// ----------------------------------------------------------------------------
// Rice bitstream writer assertion macros
// Shorthand for the concurrent checks of the writer's top level.
// ----------------------------------------------------------------------------
`ifndef RICE_BITSTREAM_WRITER_ASSERT_SVH
`define RICE_BITSTREAM_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RBW_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBW_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/rbw_pkg.sv
// ----------------------------------------------------------------------------
// Rice bitstream writer package
// Command and error codes and the work descriptor passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package rbw_pkg;

    typedef enum logic [2:0] {
        CMD_RAW    = 3'd0,
        CMD_SIGNED = 3'd1,
        CMD_UNARY  = 3'd2,
        CMD_RICE   = 3'd3,
        CMD_ZEROS  = 3'd4,
        CMD_ALIGN  = 3'd5,
        CMD_CLEAR  = 3'd6
    } rbw_cmd_t;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_RAW_WIDTH    = 3'd1;
    localparam logic [2:0] ERR_SIGNED_WIDTH = 3'd2;
    localparam logic [2:0] ERR_RICE_PARAM   = 3'd3;
    localparam logic [2:0] ERR_RUN_LENGTH   = 3'd4;

    localparam int unsigned FIELD_BITS = 64;

    // One command reduced to: a run of zeros, then a left-aligned field.
    typedef struct packed {
        logic [8:0]  zeros;       // leading zero bits
        logic [6:0]  fw;          // field width, 0..64
        logic [63:0] fval;        // field bits, first bit in bit 63
        logic [8:0]  total;       // zeros + fw
        logic        clr;         // discard the partial byte
        logic [2:0]  err;         // error code of the command
        logic [2:0]  fill_after;  // partial byte fill once the command is done
    } rbw_desc_t;

endpackage

`default_nettype wire

// File: rtl/rice_bitstream_writer.sv
// ----------------------------------------------------------------------------
// Rice bitstream writer
// Packs raw and signed fields, unary, zero-run and Rice codes MSB first and
// streams out every byte as soon as it is complete.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one command in s_tuser with its value and
// count in s_tdata. Every completed byte leaves as one output beat with
// tuser high; a command that completes no byte, or that is rejected, gives a
// single beat with tuser low carrying its error code. tlast marks the final
// beat of each command, and every beat shows the partial-byte fill once its
// command is done. The decoder takes a beat and hands it through a two-entry
// queue to the packer, so commands are accepted while earlier ones are packed.
// An idle packer loads a queued command as soon as the output register is
// free; a queued command is loaded in the cycle that finishes the one before.
// Once loaded, the packer handles one group of up to eight bits at a time;
// each group ends at a byte boundary or at the switch from the zero run to the
// field, and the output runs at one byte per cycle inside a long run while the
// receiver takes every beat. A beat passes the queue, the packer's registers
// and the output register on its way out. Reset empties the queue and the
// partial byte. When the receiver stalls the output register holds its beat,
// the packer waits, and once the queue is full s_tready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module rice_bitstream_writer
    import rbw_pkg::*;
#(
    parameter int unsigned MAX_RUN_BITS = 440
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // value [63:0], count [72:64], zeros above
    input  wire logic [2:0]  s_tuser,   // cmd [2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // out_byte [7:0], error [10:8], fill_bits [13:11]
    output logic             m_tuser,   // byte_valid
    output logic             m_tlast
);

    rbw_desc_t front_desc;
    rbw_desc_t head_desc;
    logic      push;
    logic      pop;
    logic      fifo_full;
    logic      fifo_not_empty;

    rbw_front #(
        .MAX_RUN_BITS(MAX_RUN_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .desc      (front_desc)
    );

    rbw_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (front_desc),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (fifo_not_empty),
        .head      (head_desc)
    );

    rbw_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fifo_not_empty (fifo_not_empty),
        .head           (head_desc),
        .pop            (pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

`include "rice_bitstream_writer_assert.svh"

    // A beat without a byte is always the only beat of its command.
    `RBW_ASSERT_NOW(a_null_beat_last, m_tvalid && !m_tuser, m_tlast && (m_tdata[7:0] == 8'd0), "null beat must be last and zero")

    // Completed bytes never carry an error code.
    `RBW_ASSERT_NOW(a_byte_no_error, m_tvalid && m_tuser, m_tdata[10:8] == ERR_NONE, "byte beat carries an error")

    // A full queue stays full while nothing is pushed or popped.
    `RBW_ASSERT_NEXT(a_queue_pop, fifo_full && !pop && !push, fifo_full, "queue lost an entry")

endmodule

`default_nettype wire

// File: rtl/rbw_fifo.sv
// ----------------------------------------------------------------------------
// Rice bitstream writer descriptor queue
// Two-entry queue that decouples command decoding from bit packing.
// ----------------------------------------------------------------------------
`default_nettype none

module rbw_fifo
    import rbw_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire rbw_desc_t push_desc,
    output logic           full,
    input  wire logic      pop,
    output logic           not_empty,
    output rbw_desc_t      head
);

    rbw_desc_t   mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = count_reg[1];
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rbw_front.sv
// ----------------------------------------------------------------------------
// Rice bitstream writer command decoder
// Checks each command, folds Rice values and turns the command into a
// zero run plus a left-aligned field for the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module rbw_front
    import rbw_pkg::*;
#(
    parameter int unsigned MAX_RUN_BITS = 440
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // value [63:0], count [72:64], zeros above
    input  wire logic [2:0]  s_tuser,   // cmd [2:0]
    input  wire logic        fifo_full,
    output logic             push,
    output rbw_desc_t        desc
);

    logic [2:0]  fill_reg;
    logic [2:0]  fill_next;
    rbw_cmd_t    cmd;
    logic [63:0] value;
    logic [8:0]  count;
    logic [5:0]  k;
    logic [63:0] folded;
    logic [63:0] quot;
    logic [63:0] rice_sh;
    logic [63:0] raw_left;

    assign cmd      = rbw_cmd_t'(s_tuser);
    assign value    = s_tdata[63:0];
    assign count    = s_tdata[72:64];
    assign k        = count[5:0];
    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;

    // Zigzag fold: non-negative v to 2v, negative v to -2v-1.
    assign folded   = {value[62:0], 1'b0} ^ {64{value[63]}};
    assign quot     = folded >> k;
    assign rice_sh  = folded << (7'd64 - {1'b0, k});
    assign raw_left = value << (7'd64 - count[6:0]);

    always_comb begin
        desc = '0;
        case (cmd)
            CMD_RAW: begin
                if (count > 9'd64) begin
                    desc.err = ERR_RAW_WIDTH;
                end else begin
                    desc.fw   = count[6:0];
                    desc.fval = raw_left;
                end
            end
            CMD_SIGNED: begin
                if (count == 9'd0 || count > 9'd64) begin
                    desc.err = ERR_SIGNED_WIDTH;
                end else begin
                    desc.fw   = count[6:0];
                    desc.fval = raw_left;
                end
            end
            CMD_UNARY: begin
                if (count > 9'(MAX_RUN_BITS)) begin
                    desc.err = ERR_RUN_LENGTH;
                end else begin
                    desc.zeros = count;
                    desc.fw    = 7'd1;
                    desc.fval  = {1'b1, 63'd0};
                end
            end
            CMD_RICE: begin
                if (count[8:6] != 3'd0) begin
                    desc.err = ERR_RICE_PARAM;
                end else if (quot > 64'(MAX_RUN_BITS)) begin
                    desc.err = ERR_RUN_LENGTH;
                end else begin
                    // Stop bit followed by the low k bits of the folded value.
                    desc.zeros = quot[8:0];
                    desc.fw    = {1'b0, k} + 7'd1;
                    desc.fval  = {1'b1, rice_sh[63:1]};
                end
            end
            CMD_ZEROS: begin
                if (count > 9'(MAX_RUN_BITS)) begin
                    desc.err = ERR_RUN_LENGTH;
                end else begin
                    desc.zeros = count;
                end
            end
            CMD_ALIGN: begin
                desc.zeros = {6'd0, 3'd0 - fill_reg};
            end
            CMD_CLEAR: begin
                desc.clr = 1'b1;
            end
            default: begin
            end
        endcase
        desc.total      = desc.zeros + {2'd0, desc.fw};
        desc.fill_after = desc.clr ? 3'd0 : fill_reg + desc.total[2:0];
    end

    assign fill_next = push ? desc.fill_after : fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 3'd0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rbw_back.sv
// ----------------------------------------------------------------------------
// Rice bitstream writer packer
// Shifts each descriptor's bits into the partial byte, up to one whole byte
// per cycle while the output register is free, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbw_back
    import rbw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        fifo_not_empty,
    input  wire rbw_desc_t   head,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // out_byte [7:0], error [10:8], fill_bits [13:11]
    output logic             m_tuser,   // byte_valid
    output logic             m_tlast
);

    logic        busy_reg;
    logic        busy_next;
    logic [7:0]  partial_reg;
    logic [7:0]  partial_next;
    logic [2:0]  fill_reg;
    logic [2:0]  fill_next;
    logic [8:0]  zeros_reg;
    logic [8:0]  zeros_next;
    logic [6:0]  fw_reg;
    logic [6:0]  fw_next;
    logic [63:0] fbits_reg;
    logic [63:0] fbits_next;
    logic [8:0]  rem_reg;
    logic [8:0]  rem_next;
    logic        clr_reg;
    logic        clr_next;
    logic [2:0]  err_reg;
    logic [2:0]  err_next;
    logic [2:0]  fill_after_reg;
    logic [2:0]  fill_after_next;
    logic        emitted_reg;
    logic        emitted_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        out_bv_reg;
    logic        out_bv_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic [2:0]  out_err_reg;
    logic [2:0]  out_err_next;
    logic [2:0]  out_fill_reg;
    logic [2:0]  out_fill_next;

    logic        out_free;
    logic        active;
    logic        zero_phase;
    logic [3:0]  space;
    logic [3:0]  n;
    logic [7:0]  ins;
    logic [7:0]  partial_new;
    logic [3:0]  fill_sum;
    logic        complete;
    logic [8:0]  rem_after;
    logic        finish;
    logic        emit_null;

    assign out_free = !out_valid_reg || m_tready;
    assign active   = busy_reg && out_free;

    always_comb begin
        space      = 4'd8 - {1'b0, fill_reg};
        zero_phase = (zeros_reg != 9'd0);
        if (zero_phase) begin
            n = (zeros_reg < {5'd0, space}) ? zeros_reg[3:0] : space;
        end else begin
            n = (fw_reg < {3'd0, space}) ? fw_reg[3:0] : space;
        end
        // Take the top n field bits and slot them in after the bits held.
        ins         = zero_phase ? 8'd0 : (fbits_reg[63:56] & ~(8'hFF >> n));
        partial_new = partial_reg | (ins >> fill_reg);
        fill_sum    = {1'b0, fill_reg} + n;
        complete    = fill_sum[3];
        rem_after   = rem_reg - {5'd0, n};
        finish      = active && (rem_after == 9'd0);
        emit_null   = finish && !emitted_reg && !complete;
        pop         = fifo_not_empty && out_free && (!busy_reg || finish);
    end

    always_comb begin
        busy_next       = busy_reg;
        partial_next    = partial_reg;
        fill_next       = fill_reg;
        zeros_next      = zeros_reg;
        fw_next         = fw_reg;
        fbits_next      = fbits_reg;
        rem_next        = rem_reg;
        clr_next        = clr_reg;
        err_next        = err_reg;
        fill_after_next = fill_after_reg;
        emitted_next    = emitted_reg;

        if (active) begin
            if (zero_phase) begin
                zeros_next = zeros_reg - {5'd0, n};
            end else begin
                fw_next    = fw_reg - {3'd0, n};
                fbits_next = fbits_reg << n;
            end
            partial_next = complete ? 8'd0 : partial_new;
            fill_next    = fill_sum[2:0];
            rem_next     = rem_after;
            emitted_next = emitted_reg || complete;
            if (clr_reg) begin
                partial_next = 8'd0;
                fill_next    = 3'd0;
            end
            if (finish) begin
                busy_next = 1'b0;
            end
        end

        if (pop) begin
            busy_next       = 1'b1;
            zeros_next      = head.zeros;
            fw_next         = head.fw;
            fbits_next      = head.fval;
            rem_next        = head.total;
            clr_next        = head.clr;
            err_next        = head.err;
            fill_after_next = head.fill_after;
            emitted_next    = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_bv_next    = out_bv_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        out_fill_next  = out_fill_reg;
        if (active && complete) begin
            out_valid_next = 1'b1;
            out_byte_next  = partial_new;
            out_bv_next    = 1'b1;
            // No further byte can complete once fewer than eight bits remain.
            out_last_next  = (rem_after < 9'd8);
            out_err_next   = ERR_NONE;
            out_fill_next  = fill_after_reg;
        end else if (emit_null) begin
            out_valid_next = 1'b1;
            out_byte_next  = 8'd0;
            out_bv_next    = 1'b0;
            out_last_next  = 1'b1;
            out_err_next   = err_reg;
            out_fill_next  = fill_after_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            partial_reg   <= 8'd0;
            fill_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
            emitted_reg   <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            partial_reg   <= partial_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            emitted_reg   <= emitted_next;
        end
    end

    always_ff @(posedge aclk) begin
        zeros_reg      <= zeros_next;
        fw_reg         <= fw_next;
        fbits_reg      <= fbits_next;
        rem_reg        <= rem_next;
        clr_reg        <= clr_next;
        err_reg        <= err_next;
        fill_after_reg <= fill_after_next;
        out_byte_reg   <= out_byte_next;
        out_bv_reg     <= out_bv_next;
        out_last_reg   <= out_last_next;
        out_err_reg    <= out_err_next;
        out_fill_reg   <= out_fill_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'd0, out_fill_reg, out_err_reg, out_byte_reg};
    assign m_tuser  = out_bv_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
